// ----- hw/rtl/ffl_pkg.sv -----
// ffl_pkg: action codes, status codes and fixed widths of the free frame list
// used by free_frame_list_top and ffl_store; no dependencies

package ffl_pkg;

  // fixed field widths
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned LIMIT_W = 13;

  // frames below 1 MiB are never recorded by a record word; release does not check this bound
  localparam logic [ADDR_W-1:0] LOW_FRAME_BOUND = 32'h0010_0000;

  // action codes of an input word
  typedef enum logic [1:0] {
    ACT_RECORD  = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_ACQUIRE = 2'd2,
    ACT_NONE    = 2'd3
  } ffl_action_t;

  // status codes of a result word
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_LOW   = 2'd3
  } ffl_status_t;

endpackage

// ----- hw/rtl/ffl_store.sv -----
// ffl_store: frame address memory, one write port and one registered read port
// depends on ffl_pkg for the address width

module ffl_store #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned IDX_W = 12
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [IDX_W-1:0]          wr_idx,
  input  logic [ffl_pkg::ADDR_W-1:0] wr_data,
  input  logic [IDX_W-1:0]          rd_idx,
  output logic [ffl_pkg::ADDR_W-1:0] rd_data
);
  import ffl_pkg::*;

  logic [ADDR_W-1:0] mem [DEPTH];
  logic [ADDR_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_idx];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hw/rtl/free_frame_list_top.sv -----
// free_frame_list_top: circular free list of physical frame addresses
// depends on ffl_pkg and ffl_store
//
//   channel   ports                                   handshake
//   input     in_action, in_frame_addr                start & !busy
//   result    out_frame_out, out_status, out_free_count  out_valid, one cycle
//   config    cfg_frame_limit                         cfg_valid & cfg_ready
//
// one word is taken every cycle; busy stays low
// each result appears in the cycle after its word is taken, held for one cycle
// the acquire frame comes from the store's registered read port, which reads head_r
// reset clears head, tail and count and sets frame_limit to 4096; the store is not cleared
// the receiver cannot stall; results are never held back

module free_frame_list_top #(
  parameter int unsigned DEPTH = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input words
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_action,
  input  logic [ffl_pkg::ADDR_W-1:0]    in_frame_addr,
  // result words
  output logic                          out_valid,
  output logic [ffl_pkg::ADDR_W-1:0]    out_frame_out,
  output logic [1:0]                    out_status,
  output logic [ffl_pkg::LIMIT_W-1:0]   out_free_count,
  // configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ffl_pkg::LIMIT_W-1:0]   cfg_frame_limit
);
  import ffl_pkg::*;

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [IDX_W-1:0]   head_r, head_nxt;
  logic [IDX_W-1:0]   tail_r, tail_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [LIMIT_W-1:0] limit_r;
  logic               valid_r;
  logic               acq_ok_r;
  ffl_status_t        status_r, status_nxt;

  logic               acc;
  logic               acq_ok;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_idx;
  logic [IDX_W-1:0]   head_inc, head_dec, tail_inc;
  logic               store_full, rel_full;
  logic [ADDR_W-1:0]  rd_data;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign acc       = start && !busy;

  // index wrap
  assign head_inc = (head_r == IDX_LAST) ? '0 : head_r + 1'b1;
  assign head_dec = (head_r == '0) ? IDX_LAST : head_r - 1'b1;
  assign tail_inc = (tail_r == IDX_LAST) ? '0 : tail_r + 1'b1;

  // fill checks
  assign store_full = (cnt_r >= CNT_FULL);
  assign rel_full   = (CMP_W'(cnt_r) >= CMP_W'(limit_r)) || store_full;

  // per-word decision
  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    cnt_nxt    = cnt_r;
    status_nxt = ST_OK;
    wr_en      = 1'b0;
    wr_idx     = tail_r;
    acq_ok     = 1'b0;
    case (ffl_action_t'(in_action))
      ACT_RECORD: begin
        if (in_frame_addr < LOW_FRAME_BOUND) begin
          status_nxt = ST_LOW;
        end else if (store_full) begin
          status_nxt = ST_FULL;
        end else begin
          wr_en    = acc;
          wr_idx   = tail_r;
          tail_nxt = tail_inc;
          cnt_nxt  = cnt_r + 1'b1;
        end
      end
      ACT_RELEASE: begin
        if (rel_full) begin
          status_nxt = ST_FULL;
        end else begin
          wr_en    = acc;
          wr_idx   = head_dec;
          head_nxt = head_dec;
          cnt_nxt  = cnt_r + 1'b1;
        end
      end
      ACT_ACQUIRE: begin
        if (cnt_r == '0) begin
          status_nxt = ST_EMPTY;
        end else begin
          acq_ok   = 1'b1;
          head_nxt = head_inc;
          cnt_nxt  = cnt_r - 1'b1;
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  // frame memory; the read of head_r is taken on every edge
  ffl_store #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_idx  (wr_idx),
    .wr_data (in_frame_addr),
    .rd_idx  (head_r),
    .rd_data (rd_data)
  );

  // list state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      tail_r   <= '0;
      cnt_r    <= '0;
      limit_r  <= LIMIT_W'(4096);
      valid_r  <= 1'b0;
      acq_ok_r <= 1'b0;
      status_r <= ST_OK;
    end else begin
      valid_r <= acc;
      if (acc) begin
        head_r   <= head_nxt;
        tail_r   <= tail_nxt;
        cnt_r    <= cnt_nxt;
        acq_ok_r <= acq_ok;
        status_r <= status_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_frame_limit;
      end
    end
  end

  // result word
  assign out_valid      = valid_r;
  assign out_frame_out  = acq_ok_r ? rd_data : '0;
  assign out_status     = status_r;
  assign out_free_count = LIMIT_W'(cnt_r);

  // count never passes the store depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL) else $error("free count above depth");

  // every accepted word yields a result strobe next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> out_valid) else $error("missing result strobe");

  // a refused word leaves the list untouched
  a_refused_stable: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (status_nxt != ST_OK) |=> $stable(cnt_r) && $stable(head_r) && $stable(tail_r))
    else $error("refused word changed the list");

  // only a successful acquire returns a frame
  a_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> out_frame_out == '0)
    else $error("frame returned on error");

  // nothing is written to the store without an accepted word
  a_write_acc: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> acc && (status_nxt == ST_OK)) else $error("stray store write");

endmodule
